[sv/e8cp_pkg.sv]
// Shared types and constants for the E8 lattice closest-point quantiser.
// No dependencies; imported by e8cp_coset, e8_lattice_closest_point, e8cp_point_check and the testbench top.
`default_nettype none

package e8cp_pkg;

  // Vector dimension and field widths of the transaction ports.
  localparam int DIM           = 8;
  localparam int IN_W          = 16;
  localparam int OUT_W         = 10;
  localparam int FRAC_BITS_DEF = 8;

  // Doubled coordinates are formed at this width before saturation; it holds
  // twice the largest rounded coordinate for any fraction width.
  localparam int SAT_W   = 19;
  localparam int OUT_MAX = 258;

  typedef logic signed [IN_W-1:0]  coord_t;
  typedef logic signed [OUT_W-1:0] point_t;

endpackage

`default_nettype wire

[sv/e8cp_coset.sv]
// Two-stage quantiser of one coset (D8 or D8 plus one half) to the D8 lattice.
// Depends on e8cp_pkg; instantiated twice by e8_lattice_closest_point.
`default_nettype none

module e8cp_coset import e8cp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter bit HALF_OFF  = 1'b0,
  localparam int RW = IN_W + 2 - FRAC_BITS,
  localparam int DW = 2 * FRAC_BITS + 2
) (
  input  wire logic                 clk,
  input  wire coord_t               x [DIM],
  output logic signed [RW-1:0]      pt_r [DIM],
  output logic        [DW-1:0]      dist_r
);

  localparam int VW = IN_W + 1;
  localparam int FW = FRAC_BITS + 1;
  localparam logic [FW-1:0] ONE    = FW'(1) << FRAC_BITS;
  localparam logic [FW-1:0] HALF_E = ONE >> 1;
  localparam logic signed [VW-1:0] OFF = HALF_OFF ? (VW'(1) << (FRAC_BITS - 1)) : VW'(0);

  // Stage B registers: rounded values, squared errors, flip position and parity.
  logic signed [RW-1:0]          res_r [DIM];
  logic signed [RW-1:0]          res_nxt [DIM];
  logic [2*FRAC_BITS-1:0]        sq_r [DIM];
  logic [2*FRAC_BITS-1:0]        sq_nxt [DIM];
  logic [2:0]                    k_r, k_nxt;
  logic [FRAC_BITS-1:0]          magk_r, magk_nxt;
  logic                          negk_r, negk_nxt;
  logic                          par_r, par_nxt;

  logic signed [RW-1:0]          pt_nxt [DIM];
  logic [DW-1:0]                 dist_nxt;

  // Round each shifted coordinate to the nearest integer, ties toward zero.
  // The error magnitude and its sign are kept; the largest magnitude, first
  // index on ties, marks the coordinate to round the wrong way.
  always_comb begin
    logic signed [VW-1:0]    v;
    logic signed [VW-1:0]    sh;
    logic [FW-1:0]           fz;
    logic                    up;
    logic [FRAC_BITS-1:0]    mag [DIM];
    logic [FW-1:0]           mag_w;
    logic                    neg [DIM];
    logic [FRAC_BITS-1:0]    best;
    v        = '0;
    sh       = '0;
    fz       = '0;
    up       = 1'b0;
    mag_w    = '0;
    par_nxt  = 1'b0;
    for (int i = 0; i < DIM; i++) begin
      v          = VW'(x[i]) - OFF;
      sh         = v >>> FRAC_BITS;
      fz         = {1'b0, v[FRAC_BITS-1:0]};
      up         = (fz > HALF_E) || ((fz == HALF_E) && v[VW-1]);
      res_nxt[i] = sh[RW-1:0] + (up ? RW'(1) : RW'(0));
      mag_w      = up ? (ONE - fz) : fz;
      mag[i]     = mag_w[FRAC_BITS-1:0];
      neg[i]     = up;
      sq_nxt[i]  = mag[i] * mag[i];
      par_nxt    = par_nxt ^ res_nxt[i][0];
    end
    best     = mag[0];
    k_nxt    = 3'd0;
    for (int i = 1; i < DIM; i++) begin
      if (mag[i] > best) begin
        best  = mag[i];
        k_nxt = 3'(i);
      end
    end
    magk_nxt = best;
    negk_nxt = neg[k_nxt];
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    sq_r   <= sq_nxt;
    k_r    <= k_nxt;
    magk_r <= magk_nxt;
    negk_r <= negk_nxt;
    par_r  <= par_nxt;
  end

  // Apply the wrong-way rounding on odd parity. Flipping one coordinate
  // changes its squared error by ONE^2 - 2*ONE*|err|, so the distance is the
  // sum of the plain squares plus that correction.
  always_comb begin
    logic [FW-1:0] diff;
    logic [DW-1:0] acc;
    diff = ONE - {magk_r, 1'b0};
    acc  = par_r ? (DW'(diff) << FRAC_BITS) : '0;
    for (int i = 0; i < DIM; i++) begin
      acc = acc + DW'(sq_r[i]);
      if (par_r && (k_r == 3'(i))) begin
        pt_nxt[i] = res_r[i] + (negk_r ? -RW'(1) : RW'(1));
      end else begin
        pt_nxt[i] = res_r[i];
      end
    end
    dist_nxt = acc;
  end

  always_ff @(posedge clk) begin
    pt_r   <= pt_nxt;
    dist_r <= dist_nxt;
  end

endmodule

`default_nettype wire

[sv/e8_lattice_closest_point.sv]
// Top level of the E8 lattice closest-point quantiser: input register, two
// coset quantisers (e8cp_coset) and the coset choice with output register.
// Depends on e8cp_pkg and e8cp_coset.
//
//   channel   ports                                handshake
//   -------   ----------------------------------   -------------------------
//   input     in_coord_0 .. in_coord_7             start high, busy low
//   result    out_point_0 .. out_point_7,          out_valid high for one
//             out_half_coset                       cycle per transaction
//
// One transaction is accepted every cycle; busy stays low.
// Each result passes the input register, rounding and squares, flip and
// distance sum and the coset choice register, in that order, before it is
// on the ports.
// Synchronous active-low reset clears the valid pipeline only.
// The receiver cannot stall; every result is shown once, for one cycle.
`default_nettype none

module e8_lattice_closest_point import e8cp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  output logic        busy,
  input  wire coord_t in_coord_0,
  input  wire coord_t in_coord_1,
  input  wire coord_t in_coord_2,
  input  wire coord_t in_coord_3,
  input  wire coord_t in_coord_4,
  input  wire coord_t in_coord_5,
  input  wire coord_t in_coord_6,
  input  wire coord_t in_coord_7,
  output logic        out_valid,
  output point_t      out_point_0,
  output point_t      out_point_1,
  output point_t      out_point_2,
  output point_t      out_point_3,
  output point_t      out_point_4,
  output point_t      out_point_5,
  output point_t      out_point_6,
  output point_t      out_point_7,
  output logic        out_half_coset
);

  localparam int RW = IN_W + 2 - FRAC_BITS;
  localparam int DW = 2 * FRAC_BITS + 2;
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(OUT_MAX);
  localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_W'(OUT_MAX);

  logic                  accept;
  coord_t                x_r [DIM];
  logic                  vld_a_r, vld_b_r, vld_c_r, out_valid_r;
  logic signed [RW-1:0]  pt0 [DIM];
  logic signed [RW-1:0]  pt1 [DIM];
  logic [DW-1:0]         dist0, dist1;
  point_t                point_r [DIM];
  point_t                point_nxt [DIM];
  logic                  half_r, half_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input register, loaded on each accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r[0] <= in_coord_0;
      x_r[1] <= in_coord_1;
      x_r[2] <= in_coord_2;
      x_r[3] <= in_coord_3;
      x_r[4] <= in_coord_4;
      x_r[5] <= in_coord_5;
      x_r[6] <= in_coord_6;
      x_r[7] <= in_coord_7;
    end
  end

  // Valid bits that travel alongside the data pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r     <= 1'b0;
      vld_b_r     <= 1'b0;
      vld_c_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_a_r     <= accept;
      vld_b_r     <= vld_a_r;
      vld_c_r     <= vld_b_r;
      out_valid_r <= vld_c_r;
    end
  end

  // Integer coset D8.
  e8cp_coset #(
    .FRAC_BITS (FRAC_BITS),
    .HALF_OFF  (1'b0)
  ) u_coset_int (
    .clk    (clk),
    .x      (x_r),
    .pt_r   (pt0),
    .dist_r (dist0)
  );

  // Half-integer coset D8 plus one half.
  e8cp_coset #(
    .FRAC_BITS (FRAC_BITS),
    .HALF_OFF  (1'b1)
  ) u_coset_half (
    .clk    (clk),
    .x      (x_r),
    .pt_r   (pt1),
    .dist_r (dist1)
  );

  // Pick the nearer coset (D8 on equal distance), double and saturate.
  always_comb begin
    logic signed [SAT_W-1:0] ext;
    logic signed [SAT_W-1:0] dbl;
    ext      = '0;
    dbl      = '0;
    half_nxt = dist1 < dist0;
    for (int i = 0; i < DIM; i++) begin
      ext = half_nxt ? SAT_W'(pt1[i]) : SAT_W'(pt0[i]);
      dbl = {ext[SAT_W-2:0], half_nxt};
      if (dbl > SAT_HI) begin
        dbl = SAT_HI;
      end else if (dbl < SAT_LO) begin
        dbl = SAT_LO;
      end
      point_nxt[i] = dbl[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    point_r <= point_nxt;
    half_r  <= half_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_point_0    = point_r[0];
  assign out_point_1    = point_r[1];
  assign out_point_2    = point_r[2];
  assign out_point_3    = point_r[3];
  assign out_point_4    = point_r[4];
  assign out_point_5    = point_r[5];
  assign out_point_6    = point_r[6];
  assign out_point_7    = point_r[7];
  assign out_half_coset = half_r;

  // Every accepted transaction is followed by its result strobe.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("result strobe missing after accepted transaction");

  // No result strobe without a matching accepted transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 4))
    else $error("result strobe without a matching transaction");

  // Without saturation the chosen point is a valid E8 point: odd doubled
  // coordinates on the half coset, and an even coordinate sum on D8.
  if (FRAC_BITS >= 8) begin : g_lattice_chk
    a_half_odd: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_half_coset |->
        out_point_0[0] && out_point_1[0] && out_point_2[0] && out_point_3[0] &&
        out_point_4[0] && out_point_5[0] && out_point_6[0] && out_point_7[0])
      else $error("half-coset point has an even doubled coordinate");

    a_d8_even: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && !out_half_coset |->
        !(out_point_0[1] ^ out_point_1[1] ^ out_point_2[1] ^ out_point_3[1] ^
          out_point_4[1] ^ out_point_5[1] ^ out_point_6[1] ^ out_point_7[1]))
      else $error("D8 point has an odd coordinate sum");
  end

endmodule

`default_nettype wire

[tb/sv/e8cp_point_check.sv]
// Checker for the E8 lattice closest-point quantiser: watches both channels,
// predicts each result and compares it with what the block returns.
// Depends on e8cp_pkg for the field types and widths.

module e8cp_point_check import e8cp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  coord_t [DIM-1:0]      in_coord,
  input  logic                  out_valid,
  input  point_t [DIM-1:0]      out_point,
  input  logic                  out_half_coset,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    point_t [DIM-1:0] pt;
    logic             half;
  } e8_point_t;

  localparam longint ONE_UNIT  = longint'(1) << FRAC_BITS;
  localparam longint HALF_UNIT = ONE_UNIT >> 1;

  // Points still owed by the block, oldest first.
  e8_point_t expected_points[$];
  int        failures = 0;

  // Nearest E8 point to x: quantise each coset to D8, keep the closer one
  // (D8 on a tie), then double and saturate the coordinates.
  function automatic e8_point_t e8_nearest_point(input coord_t [DIM-1:0] x);
    longint    v, a, q, r, off, cand_dist, best_dist, m, best_err, d, dbl, sum;
    longint    pt[DIM];
    longint    err[DIM];
    longint    best_pt[DIM];
    int        k;
    int        best_c;
    e8_point_t res;
    best_dist = 0;
    best_c    = 0;
    for (int c = 0; c < 2; c++) begin
      off      = (c == 1) ? HALF_UNIT : 0;
      sum      = 0;
      best_err = -1;
      k        = 0;
      // Round to nearest with ties toward zero, tracking the largest error.
      for (int i = 0; i < DIM; i++) begin
        v = longint'(x[i]) - off;
        a = (v < 0) ? -v : v;
        q = a >>> FRAC_BITS;
        r = a - (q <<< FRAC_BITS);
        if (r > HALF_UNIT) q = q + 1;
        pt[i]  = (v < 0) ? -q : q;
        err[i] = v - pt[i] * ONE_UNIT;
        sum    = sum + pt[i];
        m      = (err[i] < 0) ? -err[i] : err[i];
        if (m > best_err) begin
          best_err = m;
          k        = i;
        end
      end
      // An odd sum is fixed by rounding the worst coordinate the other way.
      if (sum[0]) pt[k] = pt[k] + ((err[k] >= 0) ? 1 : -1);
      cand_dist = 0;
      for (int i = 0; i < DIM; i++) begin
        d         = longint'(x[i]) - (pt[i] * ONE_UNIT + off);
        cand_dist = cand_dist + d * d;
      end
      if (c == 0 || cand_dist < best_dist) begin
        best_dist = cand_dist;
        best_c    = c;
        best_pt   = pt;
      end
    end
    for (int i = 0; i < DIM; i++) begin
      dbl = 2 * best_pt[i] + best_c;
      if (dbl > OUT_MAX)  dbl = OUT_MAX;
      if (dbl < -OUT_MAX) dbl = -OUT_MAX;
      res.pt[i] = point_t'(dbl);
    end
    res.half = (best_c == 1);
    return res;
  endfunction

  function automatic string point_text(input e8_point_t p);
    string s;
    s = "";
    for (int i = 0; i < DIM; i++) s = {s, $sformatf("%0d ", $signed(p.pt[i]))};
    return {s, $sformatf("half=%0b", p.half)};
  endfunction

  // Record each accepted transaction and check each result against the oldest
  // prediction.
  always @(posedge clk) begin : watch
    e8_point_t seen;
    e8_point_t want;
    logic      bad;
    if (rst_n) begin
      if (start && !busy) expected_points.push_back(e8_nearest_point(in_coord));
      if (out_valid) begin
        seen.pt   = out_point;
        seen.half = out_half_coset;
        if (expected_points.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result with no transaction waiting: %s", $realtime,
                     point_text(seen));
        end else begin
          want = expected_points.pop_front();
          bad  = (seen.half !== want.half);
          for (int i = 0; i < DIM; i++)
            if (seen.pt[i] !== want.pt[i]) bad = 1'b1;
          if (bad) begin
            failures++;
            if (failures <= 10)
              $display("%0t: mismatch: expected %s, got %s", $realtime,
                       point_text(want), point_text(seen));
          end
        end
      end
    end
    fail_count <= failures;
    pending    <= expected_points.size();
  end

endmodule

[tb/sv/tb_e8_lattice_closest_point.sv]
// Testbench top for the E8 lattice closest-point quantiser: drives directed and
// random vectors with random gaps and gives the verdict.
// Depends on e8cp_pkg, e8_lattice_closest_point and e8cp_point_check.

module tb_e8_lattice_closest_point;
  import e8cp_pkg::*;

  localparam int ITEMS     = 1500;
  localparam int BLOCK     = 100;
  localparam int DRAIN_MAX = 200;
  localparam int TAIL      = 8;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  coord_t [DIM-1:0] in_coord;
  logic             out_valid;
  point_t           out_point_0, out_point_1, out_point_2, out_point_3;
  point_t           out_point_4, out_point_5, out_point_6, out_point_7;
  logic             out_half_coset;
  int               fail_count;
  int               pending;

  e8_lattice_closest_point dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_coord_0     (in_coord[0]),
    .in_coord_1     (in_coord[1]),
    .in_coord_2     (in_coord[2]),
    .in_coord_3     (in_coord[3]),
    .in_coord_4     (in_coord[4]),
    .in_coord_5     (in_coord[5]),
    .in_coord_6     (in_coord[6]),
    .in_coord_7     (in_coord[7]),
    .out_valid      (out_valid),
    .out_point_0    (out_point_0),
    .out_point_1    (out_point_1),
    .out_point_2    (out_point_2),
    .out_point_3    (out_point_3),
    .out_point_4    (out_point_4),
    .out_point_5    (out_point_5),
    .out_point_6    (out_point_6),
    .out_point_7    (out_point_7),
    .out_half_coset (out_half_coset)
  );

  e8cp_point_check check_points (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_coord       (in_coord),
    .out_valid      (out_valid),
    .out_point      ({out_point_7, out_point_6, out_point_5, out_point_4,
                      out_point_3, out_point_2, out_point_1, out_point_0}),
    .out_half_coset (out_half_coset),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // Random vector, mostly shaped around lattice points, rounding ties and the
  // extremes of the range, with some fully random words.
  function automatic coord_t [DIM-1:0] rand_vector();
    coord_t [DIM-1:0] v;
    int               kind;
    int               base;
    int               val;
    int               fracs[8];
    int               edges[6];
    fracs = '{0, 128, -128, 127, 129, -127, -129, 64};
    edges = '{-32768, 32767, -32640, 32640, -32767, 0};
    kind  = $urandom_range(0, 9);
    for (int i = 0; i < DIM; i++) begin
      base = $urandom_range(0, 252) - 126;
      case (kind)
        0, 1:    val = $urandom;
        2, 3, 4: val = base * 256 + fracs[$urandom_range(0, 7)];
        5, 6:    val = base * 256 + 128 + $urandom_range(0, 80) - 40;
        7, 8:    val = ($urandom_range(0, 8) - 4) * 256 + $urandom_range(0, 120) - 60;
        default: val = edges[$urandom_range(0, 5)];
      endcase
      v[i] = coord_t'(val);
    end
    return v;
  endfunction

  // Gap after a transaction: mostly none or short, now and then long; a steady
  // stretch has no gaps at all.
  function automatic int rand_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one vector and hold it until the block takes it.
  task automatic send_vector(input coord_t [DIM-1:0] v);
    start    <= 1'b1;
    in_coord <= v;
    do @(posedge clk); while (busy);
  endtask

  // Idle for a number of cycles with junk on the data ports.
  task automatic pause(input int gap);
    if (gap > 0) begin
      start    <= 1'b0;
      in_coord <= rand_vector();
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every outstanding result has come back.
  task automatic drain();
    int w;
    start <= 1'b0;
    @(posedge clk);
    for (w = 0; pending != 0 && w < DRAIN_MAX; w++) @(posedge clk);
  endtask

  initial begin
    coord_t [DIM-1:0] v;
    int               pat[DIM];
    bit               steady;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_coord <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed vectors: range extremes, rounding ties, wrong-way rounding,
    // equal coset distances and bit patterns.
    for (int n = 0; n < 21; n++) begin
      case (n)
        0:       pat = '{default: 0};
        1:       pat = '{default: 32767};
        2:       pat = '{default: -32768};
        3:       pat = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
        4:       pat = '{default: 128};
        5:       pat = '{default: -128};
        6:       pat = '{128, 0, 0, 0, 0, 0, 0, 0};
        7:       pat = '{256, 0, 0, 0, 0, 0, 0, 0};
        8:       pat = '{-256, 0, 0, 0, 0, 0, 0, 0};
        9:       pat = '{default: 64};
        10:      pat = '{default: -64};
        11:      pat = '{77, 77, 0, 0, 0, 0, 0, 0};
        12:      pat = '{300, 500, -700, 1000, -1300, 20, -5, 384};
        13:      pat = '{default: 21845};
        14:      pat = '{default: -21846};
        15:      pat = '{384, 128, -128, -384, 640, -640, 896, -896};
        16:      pat = '{383, 129, -127, -385, 639, -641, 897, -895};
        17:      pat = '{32640, -32640, 32767, -32768, 32512, -32512, 128, -128};
        18:      pat = '{-60, 256, 0, 0, 0, 0, 0, 0};
        19:      pat = '{default: 192};
        default: pat = '{1, -1, 2, -2, 3, -3, 4, -4};
      endcase
      for (int i = 0; i < DIM; i++) v[i] = coord_t'(pat[i]);
      send_vector(v);
      pause(rand_gap(1'b0));
    end
    drain();

    // Random vectors in blocks, some blocks back to back, with one full drain
    // half way through.
    for (int blk = 0; blk < ITEMS / BLOCK; blk++) begin
      steady = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < BLOCK; j++) begin
        send_vector(rand_vector());
        pause(rand_gap(steady));
      end
      if (blk == ITEMS / BLOCK / 2) drain();
    end

    drain();
    repeat (TAIL) @(posedge clk);
    if (fail_count + pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/e8cp_pkg.sv
sv/e8cp_coset.sv
sv/e8_lattice_closest_point.sv
tb/sv/e8cp_point_check.sv
tb/sv/tb_e8_lattice_closest_point.sv
